[rtl/mrwp_pkg.sv]
// Package for the register-write parser: message codes, byte masks and the
// state and result types that pass between the step logic and the top level.
// Depends on nothing.
package mrwp_pkg;

	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned ADDR_W   = 9;
	localparam int unsigned DATA_W   = 8;
	localparam int unsigned VOL_W    = 7;
	localparam int unsigned FILL_W   = 2;

	localparam logic [7:0] NOTE_MASK   = 8'hF8;
	localparam logic [7:0] NOTE_STATUS = 8'h90;
	localparam logic [7:0] VOL_STATUS  = 8'hC0;

	localparam logic [FILL_W-1:0] FILL_EMPTY = 2'd0;
	localparam logic [FILL_W-1:0] FILL_ONE   = 2'd1;
	localparam logic [FILL_W-1:0] FILL_TWO   = 2'd2;
	localparam logic [FILL_W-1:0] FILL_FULL  = 2'd3;

	localparam logic KIND_WRITE  = 1'b0;
	localparam logic KIND_VOLUME = 1'b1;

	typedef struct packed {
		logic [BYTE_W-1:0] first_byte;
		logic [6:0]        second_byte;
		logic [FILL_W-1:0] fill_count;
	} msg_state_t;

	typedef struct packed {
		logic              valid;
		logic              kind;
		logic [ADDR_W-1:0] reg_addr;
		logic [DATA_W-1:0] reg_data;
		logic [VOL_W-1:0]  volume;
	} msg_result_t;

endpackage

[rtl/mrwp_step.sv]
// Combinational step of the parser: one byte against the gathered message
// gives the next message state and at most one result.
// Depends on mrwp_pkg.
module mrwp_step (
	input  logic [7:0]           byte_cur,
	input  mrwp_pkg::msg_state_t state_cur,
	output mrwp_pkg::msg_state_t state_nxt,
	output mrwp_pkg::msg_result_t result
);
	import mrwp_pkg::*;

	logic [FILL_W-1:0] fill_eff;
	logic [FILL_W-1:0] fill_inc;
	logic [7:0]        first_nxt;
	logic [6:0]        second_nxt;
	logic              is_write;
	logic              is_volume;

	always_comb begin
		// A status byte restarts the message.
		fill_eff   = byte_cur[7] ? FILL_EMPTY : state_cur.fill_count;
		fill_inc   = fill_eff + FILL_ONE;
		first_nxt  = (fill_eff == FILL_EMPTY) ? byte_cur : state_cur.first_byte;
		second_nxt = (fill_eff == FILL_ONE) ? byte_cur[6:0] : state_cur.second_byte;
		is_write   = ((first_nxt & NOTE_MASK) == NOTE_STATUS) && (fill_inc == FILL_FULL);
		is_volume  = (first_nxt == VOL_STATUS) && (fill_inc == FILL_TWO);

		result          = '0;
		state_nxt       = state_cur;
		if (fill_eff != FILL_FULL) begin
			state_nxt.first_byte  = first_nxt;
			state_nxt.second_byte = second_nxt;
			state_nxt.fill_count  = (is_write || is_volume) ? FILL_EMPTY : fill_inc;
		end
		// When the message is full, further data bytes are dropped.
		if (fill_eff != FILL_FULL && is_write) begin
			result.valid    = 1'b1;
			result.kind     = KIND_WRITE;
			result.reg_addr = {first_nxt[1:0], second_nxt};
			result.reg_data = {first_nxt[2], byte_cur[6:0]};
		end else if (fill_eff != FILL_FULL && is_volume) begin
			result.valid  = 1'b1;
			result.kind   = KIND_VOLUME;
			result.volume = second_nxt;
		end
	end

endmodule

[rtl/midi_register_write_parser.sv]
// Register-write parser top level: input register, message state, result register.
// A byte accepted at the input is held in the input register, goes through the step
// logic and has its result held in the result register, which drives the outputs.
// Throughput: one byte per cycle while the result side does not stall.
// Reset (arst_n low, asynchronous) empties both stages and the message.
// Depends on mrwp_pkg and mrwp_step.
module midi_register_write_parser (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [7:0]                 byte_in,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic                       kind,
	output logic [8:0]                 reg_addr,
	output logic [7:0]                 reg_data,
	output logic [6:0]                 volume
);
	import mrwp_pkg::*;

	// Input stage: the accepted byte is registered here before the step logic takes it.
	logic        valid_s1;
	logic [7:0]  byte_s1;

	// Gathered message: first byte, low bits of the second byte and the fill
	// count. The fill count decides which bytes are meaningful.
	msg_state_t  state_q;
	msg_state_t  state_nxt;
	msg_result_t result;

	// Result register.
	logic        out_valid_q;
	msg_result_t out_q;

	logic        advance;

	mrwp_step u_step (
		.byte_cur  (byte_s1),
		.state_cur (state_q),
		.state_nxt (state_nxt),
		.result    (result)
	);

	// The byte in the input stage can move on unless it makes a result
	// while the result register holds one that is stalled.
	assign advance  = !result.valid || !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= byte_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (valid_s1 && advance) begin
			state_q <= state_nxt;
		end
	end

	// The result register holds while its transaction is stalled and
	// otherwise takes whatever the input stage produces this cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!(out_valid_q && out_stall)) begin
			out_valid_q <= valid_s1 && result.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!(out_valid_q && out_stall) && valid_s1 && result.valid) begin
			out_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign kind      = out_q.kind;
	assign reg_addr  = out_q.reg_addr;
	assign reg_data  = out_q.reg_data;
	assign volume    = out_q.volume;

endmodule

[bench/tb_top.sv]
`timescale 1ns / 100ps
// Self-checking bench for midi_register_write_parser: byte stream in, register writes and
// volume settings out, checked against an in-bench message parser.
// Depends on mrwp_pkg and the parser RTL.
module tb_top;
	import mrwp_pkg::*;

	// The watchdog gives up after this many cycles with no transaction on either side.
	// The longest quiet stretch in a correct run is the receiver hold-off below.
	localparam int IDLE_LIMIT   = 2000;
	localparam int HOLD_CYCLES  = 300;
	localparam int HOLD_AFTER   = 150;
	localparam int TAIL_CYCLES  = 10;
	localparam int BYTE_TARGET  = 1950;

	// Receiver stall patterns.
	typedef enum logic [1:0] {RX_FREE, RX_RANDOM, RX_PERIODIC, RX_HEAVY} rx_mode_t;

	// One pending input byte. A set hold_for_drain makes the sender wait until every
	// expected message has come out before it offers this byte.
	typedef struct packed {
		logic [BYTE_W-1:0] value;
		logic              hold_for_drain;
	} midi_byte_t;

	// One decoded message as it should appear at the result side.
	typedef struct packed {
		logic              kind;
		logic [ADDR_W-1:0] reg_addr;
		logic [DATA_W-1:0] reg_data;
		logic [VOL_W-1:0]  volume;
	} parsed_msg_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [BYTE_W-1:0] byte_in = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic              kind;
	logic [ADDR_W-1:0] reg_addr;
	logic [DATA_W-1:0] reg_data;
	logic [VOL_W-1:0]  volume;

	midi_byte_t  byte_q[$];
	parsed_msg_t msg_q[$];

	// Parser state as the bench sees it.
	logic [BYTE_W-1:0] msg_first = '0;
	logic [6:0]        msg_second = '0;
	logic [FILL_W-1:0] msg_fill = FILL_EMPTY;

	int  error_count = 0;
	int  msgs_seen = 0;
	int  idle_cycles = 0;
	bit  drain_next = 1'b0;
	bit  winding_down = 1'b0;

	midi_register_write_parser i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.byte_in  (byte_in),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.kind     (kind),
		.reg_addr (reg_addr),
		.reg_data (reg_data),
		.volume   (volume)
	);

	always #1 clk = ~clk;

	// Feeds one byte into the bench parser. Returns 1 and fills msg when the byte
	// completes a register write or a volume setting.
	function automatic bit parse_byte(input logic [BYTE_W-1:0] b, output parsed_msg_t msg);
		msg = '0;
		// A status byte always throws away whatever was gathered so far.
		if (b[7])
			msg_fill = FILL_EMPTY;
		// A full message with no result swallows data bytes until the next status.
		if (msg_fill == FILL_FULL)
			return 1'b0;
		if (msg_fill == FILL_EMPTY)
			msg_first = b;
		else if (msg_fill == FILL_ONE)
			msg_second = b[6:0];
		msg_fill = msg_fill + 1'b1;
		if ((msg_first & NOTE_MASK) == NOTE_STATUS && msg_fill == FILL_FULL) begin
			msg.kind     = KIND_WRITE;
			msg.reg_addr = {msg_first[1:0], msg_second};
			msg.reg_data = {msg_first[2], b[6:0]};
			msg_fill     = FILL_EMPTY;
			return 1'b1;
		end
		if (msg_first == VOL_STATUS && msg_fill == FILL_TWO) begin
			msg.kind   = KIND_VOLUME;
			msg.volume = msg_second;
			msg_fill   = FILL_EMPTY;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic void push_byte(input logic [BYTE_W-1:0] b);
		byte_q.push_back('{value: b, hold_for_drain: drain_next});
		drain_next = 1'b0;
	endfunction

	task automatic report_mismatch(input string what);
		error_count++;
		$display("[%0t] mismatch: %s", $time, what);
	endtask

	// Stimulus, reset and the end of the run.
	initial begin
		int          pick;
		int          count;
		int          msg_idx;
		logic [7:0]  status;

		// Directed part. Register writes at both address and data extremes.
		push_byte(8'h90); push_byte(8'h00); push_byte(8'h00);
		push_byte(8'h97); push_byte(8'h7F); push_byte(8'h7F);
		push_byte(8'h95); push_byte(8'h2A); push_byte(8'h55);
		// Volume settings at both ends of the range.
		push_byte(8'hC0); push_byte(8'h00);
		push_byte(8'hC0); push_byte(8'h7F);
		// Data with no status in front: it fills the message and is then dropped.
		push_byte(8'h33); push_byte(8'h01); push_byte(8'h02); push_byte(8'h03);
		// A status that never produces a result, followed by data past the full mark.
		push_byte(8'hC1); push_byte(8'h10); push_byte(8'h20); push_byte(8'h30);
		// A write cut short by a volume status, which then completes.
		push_byte(8'h92); push_byte(8'h11); push_byte(8'hC0); push_byte(8'h22);
		// Back-to-back status bytes.
		push_byte(8'hFF); push_byte(8'h80);

		// The first random byte waits for the directed results to drain.
		drain_next = 1'b1;
		msg_idx = 0;
		// Random part: mostly well-formed messages with random content, the rest is
		// cut-short messages, other status values and raw noise.
		while (byte_q.size() < BYTE_TARGET) begin
			if (msg_idx == 300)
				drain_next = 1'b1;
			pick = $urandom_range(0, 9);
			if (pick <= 4) begin
				push_byte(8'h90 | 8'($urandom_range(0, 7)));
				push_byte(8'($urandom_range(0, 127)));
				push_byte(8'($urandom_range(0, 127)));
			end else if (pick <= 6) begin
				push_byte(VOL_STATUS);
				push_byte(8'($urandom_range(0, 127)));
			end else if (pick == 7) begin
				// A message that stops one byte early.
				status = ($urandom_range(0, 1) == 0)
					? VOL_STATUS : (8'h90 | 8'($urandom_range(0, 7)));
				push_byte(status);
				if (status != VOL_STATUS)
					push_byte(8'($urandom_range(0, 127)));
			end else if (pick == 8) begin
				push_byte(8'($urandom_range(128, 255)));
				count = $urandom_range(0, 5);
				repeat (count) push_byte(8'($urandom_range(0, 127)));
			end else begin
				count = $urandom_range(1, 5);
				repeat (count) push_byte(8'($urandom_range(0, 255)));
			end
			msg_idx++;
		end

		repeat (6) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (byte_q.size() != 0 || in_valid)
			@(posedge clk);
		while (msg_q.size() != 0)
			@(posedge clk);
		// Stop stalling so that any stray result would still show up.
		winding_down <= 1'b1;
		repeat (TAIL_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	// Sender: predicts on every accepted byte, then decides what to offer next.
	// It sends in bursts of random length with random gaps between them, skips its
	// gaps while the receiver holds off so that the parser fills up, and honors the
	// drain marks in the byte queue.
	int          burst_left = 0;
	int          gap_left = 0;
	bit          tx_done;
	bit          launch;
	midi_byte_t  next_byte;
	parsed_msg_t new_msg;
	bit          rx_holding;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			byte_in  <= '0;
		end else begin
			tx_done = in_valid && !in_stall;
			if (tx_done) begin
				if (parse_byte(byte_in, new_msg))
					msg_q.push_back(new_msg);
			end
			// A stalled byte stays on the port untouched.
			if (!(in_valid && !tx_done)) begin
				launch = 1'b0;
				if (gap_left != 0 && !rx_holding)
					gap_left--;
				else if (byte_q.size() != 0
						&& !(byte_q[0].hold_for_drain && msg_q.size() != 0))
					launch = 1'b1;
				if (launch) begin
					next_byte = byte_q.pop_front();
					byte_in <= next_byte.value;
					if (burst_left == 0)
						burst_left = $urandom_range(1, 48);
					burst_left--;
					if (burst_left == 0)
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
				end
				in_valid <= launch;
			end
		end
	end

	// Receiver: switches between stall patterns every so often, and once holds off
	// for a long stretch after enough messages have passed.
	rx_mode_t rx_mode = RX_FREE;
	int       mode_left = 0;
	int       hold_left = 0;
	bit       hold_done = 1'b0;
	int       rx_phase = 0;
	bit       stall_next;

	assign rx_holding = (hold_left != 0);

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (hold_left != 0) begin
				hold_left--;
				stall_next = 1'b1;
			end else if (!hold_done && msgs_seen >= HOLD_AFTER) begin
				hold_left  = HOLD_CYCLES;
				hold_done  = 1'b1;
				stall_next = 1'b1;
			end else if (winding_down) begin
				stall_next = 1'b0;
			end else begin
				if (mode_left == 0) begin
					rx_mode   = rx_mode_t'($urandom_range(0, 3));
					mode_left = $urandom_range(16, 200);
				end
				mode_left--;
				rx_phase++;
				case (rx_mode)
					RX_FREE:     stall_next = 1'b0;
					RX_RANDOM:   stall_next = ($urandom_range(0, 1) != 0);
					RX_PERIODIC: stall_next = (rx_phase % 3) == 0;
					default:     stall_next = $urandom_range(0, 4) != 0;
				endcase
			end
			out_stall <= stall_next;
		end
	end

	// Monitor: every accepted result is matched against the oldest expected message.
	parsed_msg_t want;

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			msgs_seen++;
			if (msg_q.size() == 0) begin
				report_mismatch($sformatf("unexpected result kind=%0d addr=%0h data=%0h vol=%0h",
					kind, reg_addr, reg_data, volume));
			end else begin
				want = msg_q.pop_front();
				if (kind !== want.kind)
					report_mismatch($sformatf("kind %0d, expected %0d", kind, want.kind));
				if (reg_addr !== want.reg_addr)
					report_mismatch($sformatf("reg_addr %0h, expected %0h",
						reg_addr, want.reg_addr));
				if (reg_data !== want.reg_data)
					report_mismatch($sformatf("reg_data %0h, expected %0h",
						reg_data, want.reg_data));
				if (volume !== want.volume)
					report_mismatch($sformatf("volume %0h, expected %0h", volume, want.volume));
			end
		end
	end

	// Watchdog: a run that stops moving on both sides has hung.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

endmodule

[files.f]
rtl/mrwp_pkg.sv
rtl/mrwp_step.sv
rtl/midi_register_write_parser.sv
bench/tb_top.sv
